// ===== sv/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// Types, constants and the round function of the 64-bit Feistel block cipher
// (32 rounds, tc26-Z substitution boxes, rotate left by 11).
// ----------------------------------------------------------------------------
`default_nettype none

package gbc_pkg;

	localparam int unsigned HALF_W     = 32;
	localparam int unsigned BLOCK_W    = 2 * HALF_W;
	localparam int unsigned NUM_ROUNDS = 32;
	localparam int unsigned NUM_KEYS   = 8;
	localparam int unsigned KEY_IDX_W  = 3;
	localparam int unsigned NUM_SBOX   = 8;
	localparam int unsigned ROT_AMT    = 11;

	typedef logic [HALF_W-1:0]                half_t;
	typedef logic [KEY_IDX_W-1:0]             key_idx_t;
	typedef logic [NUM_KEYS-1:0][HALF_W-1:0]  key_bank_t;

	// one item as it moves between rounds
	typedef struct packed {
		half_t left;
		half_t right;
		logic  fwd;
	} stage_t;

	localparam logic [3:0] SBOX [NUM_SBOX][16] = '{
		'{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
		  4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
		'{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
		  4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
		'{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
		  4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
		'{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
		  4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
		'{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
		  4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
		'{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
		  4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
		'{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
		  4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
		'{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
		  4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
	};

	// key word used by each round in encrypt order
	localparam key_idx_t KEY_ORDER [NUM_ROUNDS] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
	};

	// add key, substitute nibble by nibble, rotate left
	function automatic half_t round_f(input half_t half, input half_t key);
		half_t sum;
		half_t sub;
		sum = half + key;
		for (int n = 0; n < NUM_SBOX; n++) begin
			sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
		end
		return {sub[HALF_W-ROT_AMT-1:0], sub[HALF_W-1:HALF_W-ROT_AMT]};
	endfunction

endpackage

`default_nettype wire

// ===== sv/gbc_keys.sv =====
// ----------------------------------------------------------------------------
// gbc_keys
// Eight 32-bit key word registers, written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_keys (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire gbc_pkg::key_idx_t  cfg_index,
	input  wire gbc_pkg::half_t     cfg_data,
	output gbc_pkg::key_bank_t      keys
);

	gbc_pkg::key_bank_t keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
		end else if (cfg_we) begin
			keys_q[cfg_index] <= cfg_data;
		end
	end

	assign keys = keys_q;

	a_key_written: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> keys_q[$past(cfg_index)] == $past(cfg_data))
		else $error("key word not updated by config write");

endmodule

`default_nettype wire

// ===== sv/gbc_round.sv =====
// ----------------------------------------------------------------------------
// gbc_round
// One cipher round and its pipeline register. The stage holds while the next
// stage is full and stalled, and takes a new item whenever it is empty or
// its content moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module gbc_round #(
	parameter int unsigned ROUND = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gbc_pkg::key_bank_t  keys,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire gbc_pkg::stage_t     in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output gbc_pkg::stage_t          out_data
);

	localparam gbc_pkg::key_idx_t KeyFwd = gbc_pkg::KEY_ORDER[ROUND];
	localparam gbc_pkg::key_idx_t KeyRev = gbc_pkg::KEY_ORDER[gbc_pkg::NUM_ROUNDS - 1 - ROUND];

	logic            valid_s1;
	gbc_pkg::stage_t data_s1;
	gbc_pkg::half_t  key;
	gbc_pkg::stage_t next;

	always_comb begin
		key        = in_data.fwd ? keys[KeyFwd] : keys[KeyRev];
		next.left  = in_data.right ^ gbc_pkg::round_f(in_data.left, key);
		next.right = in_data.left;
		next.fwd   = in_data.fwd;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

// ===== sv/gost_block_cipher_64_top.sv =====
// ----------------------------------------------------------------------------
// gost_block_cipher_64_top
// 64-bit Feistel block cipher, 32 rounds, one round per pipeline stage.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata = block_in, tuser = forward
// m_*       out  m_tvalid/m_tready  tdata = block_out
// cfg_*     in   cfg_we             cfg_index = key word, cfg_data = value
//
// one block per cycle sustained while m_tready stays high; one stage per
// round (the add, s-box and xor of a round set each stage)
// reset clears all stage valids and the eight key words
// a stage holds while the one after it is full and stalled; empty stages
// keep taking beats, so bubbles are squeezed out under output backpressure
// ----------------------------------------------------------------------------
`default_nettype none

module gost_block_cipher_64_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [gbc_pkg::KEY_IDX_W-1:0]  cfg_index,
	input  wire logic [gbc_pkg::HALF_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [gbc_pkg::BLOCK_W-1:0]    s_tdata,   // [63:0] block_in
	input  wire logic                           s_tuser,   // [0] forward
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [gbc_pkg::BLOCK_W-1:0]         m_tdata    // [63:0] block_out
);

	localparam int unsigned NR = gbc_pkg::NUM_ROUNDS;

	gbc_pkg::key_bank_t keys;
	gbc_pkg::stage_t    stg   [NR+1];
	logic               vld   [NR+1];
	logic               rdy   [NR+1];

	gbc_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keys      (keys)
	);

	// low half of the block is the left half
	assign stg[0] = '{
		left:  s_tdata[gbc_pkg::HALF_W-1:0],
		right: s_tdata[gbc_pkg::BLOCK_W-1:gbc_pkg::HALF_W],
		fwd:   s_tuser
	};
	assign vld[0]   = s_tvalid;
	assign s_tready = rdy[0];

	for (genvar r = 0; r < NR; r++) begin : g_round
		gbc_round #(
			.ROUND (r)
		) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.keys      (keys),
			.in_valid  (vld[r]),
			.in_ready  (rdy[r]),
			.in_data   (stg[r]),
			.out_valid (vld[r+1]),
			.out_ready (rdy[r+1]),
			.out_data  (stg[r+1])
		);
	end

	// final swap: right half low, left half high
	assign rdy[NR]  = m_tready;
	assign m_tvalid = vld[NR];
	assign m_tdata  = {stg[NR].left, stg[NR].right};

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output side is free");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld[1])
		else $error("accepted beat did not reach first stage");

	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[1] && !rdy[1]) |=> vld[1] && $stable(stg[1]))
		else $error("stalled first stage lost its beat");

endmodule

`default_nettype wire

// ===== tb/tb_gost_block_cipher_64_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gost_block_cipher_64_top
// Streams blocks through the 32-round cipher and checks every output beat
// in order against a behavioral copy of the cipher. A short table of fixed
// vectors comes first: zero key after reset, extreme blocks, both key orders
// and a published encrypt/decrypt pair. Four random phases follow, each with
// its own key and its own mix of input gaps and output backpressure.
// ----------------------------------------------------------------------------

module tb_gost_block_cipher_64_top;

	localparam int PHASE_BLOCKS = 450;
	localparam int STD_KEY_ROW  = 9;

	localparam logic [3:0] SBOX_Z [8][16] = '{
		'{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
		  4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
		'{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
		  4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
		'{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
		  4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
		'{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
		  4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
		'{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
		  4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
		'{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
		  4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
		'{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
		  4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
		'{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
		  4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
	};

	// published 256-bit test key, word 0 first in the key schedule
	localparam gbc_pkg::key_bank_t STD_KEY = {
		32'hfcfdfeff, 32'hf8f9fafb, 32'hf4f5f6f7, 32'hf0f1f2f3,
		32'h33221100, 32'h77665544, 32'hbbaa9988, 32'hffeeddcc
	};

	typedef struct packed {
		logic [gbc_pkg::BLOCK_W-1:0] blk;
		logic                        fwd;
		logic                        known;
		logic [gbc_pkg::BLOCK_W-1:0] result;
	} vector_t;

	// rows before the standard key row run on the all-zero key left by reset
	localparam vector_t DIRECTED [15] = '{
		'{64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0},
		'{64'h0000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
		'{64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 64'h0},
		'{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'h0},
		'{64'h0000_0000_ffff_ffff, 1'b1, 1'b0, 64'h0},
		'{64'hffff_ffff_0000_0000, 1'b0, 1'b0, 64'h0},
		'{64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
		'{64'h5555_5555_5555_5555, 1'b1, 1'b0, 64'h0},
		'{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, 64'h0},
		'{64'hfedc_ba98_7654_3210, 1'b1, 1'b1, 64'h4ee9_01e5_c2d8_ca3d},
		'{64'h4ee9_01e5_c2d8_ca3d, 1'b0, 1'b1, 64'hfedc_ba98_7654_3210},
		'{64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0},
		'{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'h0},
		'{64'h0123_4567_89ab_cdef, 1'b1, 1'b0, 64'h0},
		'{64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 64'h0}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [gbc_pkg::KEY_IDX_W-1:0] cfg_index;
	logic [gbc_pkg::HALF_W-1:0]    cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [gbc_pkg::BLOCK_W-1:0]   s_tdata;   // [63:0] block_in
	logic                          s_tuser;   // [0] forward
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [gbc_pkg::BLOCK_W-1:0]   m_tdata;   // [63:0] block_out

	logic [gbc_pkg::HALF_W-1:0]  key_model [gbc_pkg::NUM_KEYS];
	logic [gbc_pkg::BLOCK_W-1:0] cipher_results [$];
	int                          idle_pct;
	int                          stall_pct;
	int                          fail_count = 0;

	gost_block_cipher_64_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [gbc_pkg::BLOCK_W-1:0] magma_crypt(
		input logic [gbc_pkg::BLOCK_W-1:0] blk, input logic fwd);
		logic [gbc_pkg::HALF_W-1:0] lh;
		logic [gbc_pkg::HALF_W-1:0] rh;
		logic [gbc_pkg::HALF_W-1:0] sum;
		logic [gbc_pkg::HALF_W-1:0] sub;
		logic [gbc_pkg::HALF_W-1:0] nl;
		int                         pos;
		int                         widx;
		lh = blk[31:0];
		rh = blk[63:32];
		for (int r = 0; r < 32; r++) begin
			pos = fwd ? r : 31 - r;
			// three ascending passes over the key, then one descending
			widx = (pos < 24) ? pos % 8 : 31 - pos;
			sum = lh + key_model[widx];
			for (int n = 0; n < 8; n++)
				sub[4*n +: 4] = SBOX_Z[n][sum[4*n +: 4]];
			nl = rh ^ {sub[20:0], sub[31:21]};
			rh = lh;
			lh = nl;
		end
		return {lh, rh};
	endfunction

	// one input beat; stays valid until accepted, then maybe idles a while
	task automatic send_block(input logic [gbc_pkg::BLOCK_W-1:0] blk, input logic fwd,
		input logic [gbc_pkg::BLOCK_W-1:0] want);
		s_tvalid <= 1'b1;
		s_tdata  <= blk;
		s_tuser  <= fwd;
		do @(posedge clk); while (!s_tready);
		cipher_results.push_back(want);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (cipher_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_keys(input gbc_pkg::key_bank_t bank);
		drain();
		for (int i = 0; i < gbc_pkg::NUM_KEYS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= gbc_pkg::key_idx_t'(i);
			cfg_data  <= bank[i];
			key_model[i] = bank[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : check_out
		logic [gbc_pkg::BLOCK_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_results.size() == 0) begin
				$error("block_out: unexpected beat, actual %h", m_tdata);
				fail_count++;
			end else begin
				want = cipher_results.pop_front();
				if (m_tdata !== want) begin
					$error("block_out: expected %h, actual %h", want, m_tdata);
					fail_count++;
				end
			end
		end
	end

	initial begin
		gbc_pkg::key_bank_t          bank;
		logic [gbc_pkg::BLOCK_W-1:0] blk;
		logic                        fwd;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		for (int i = 0; i < gbc_pkg::NUM_KEYS; i++)
			key_model[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIRECTED); r++) begin
			if (r == STD_KEY_ROW)
				load_keys(STD_KEY);
			send_block(DIRECTED[r].blk, DIRECTED[r].fwd, DIRECTED[r].known ?
				DIRECTED[r].result : magma_crypt(DIRECTED[r].blk, DIRECTED[r].fwd));
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: bank = '1;
				2: for (int i = 0; i < gbc_pkg::NUM_KEYS; i++)
					bank[i] = i[0] ? 32'h7fff_ffff : 32'h8000_0000;
				default: for (int i = 0; i < gbc_pkg::NUM_KEYS; i++)
					bank[i] = $urandom;
			endcase
			load_keys(bank);
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				// hold off mid-phase until the pipeline has emptied
				if (n == PHASE_BLOCKS / 2)
					drain();
				case ($urandom_range(15))
					0: blk = '0;
					1: blk = '1;
					default: blk = {$urandom, $urandom};
				endcase
				fwd = 1'($urandom_range(1));
				send_block(blk, fwd, magma_crypt(blk, fwd));
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("tb_gost_block_cipher_64_top: PASS");
		else
			$display("tb_gost_block_cipher_64_top: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_gost_block_cipher_64_top: FAIL");
		$finish;
	end

endmodule

// ===== gost_block_cipher_64_top.f =====
sv/gbc_pkg.sv
sv/gbc_keys.sv
sv/gbc_round.sv
sv/gost_block_cipher_64_top.sv
tb/tb_gost_block_cipher_64_top.sv
